/* rtl/fbfill_pkg.sv */
// Shared definitions for the framebuffer pixel and fill engine.
// Holds field widths, command codes and the controller/datapath interface structs.
// Depends on nothing; every other file of the block but fbfill_ram uses it.
package fbfill_pkg;

   // Default screen geometry.
   localparam int SCREEN_WIDTH_DEF  = 320;
   localparam int SCREEN_HEIGHT_DEF = 240;

   // Field widths of the request and response.
   localparam int CMD_W    = 2;
   localparam int COORD_W  = 12;
   localparam int SIZE_W   = 11;
   localparam int COLOR_W  = 16;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 16;

   // Bit positions of the fields inside the request data word.
   localparam int POS_X_LSB  = 0;
   localparam int POS_Y_LSB  = POS_X_LSB + COORD_W;
   localparam int RECT_W_LSB = POS_Y_LSB + COORD_W;
   localparam int RECT_H_LSB = RECT_W_LSB + SIZE_W;
   localparam int COLOR_LSB  = RECT_H_LSB + SIZE_W;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FILL  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic calc;
      logic pix_write;
      logic pix_read;
      logic fill_step;
      logic clear_step;
      logic rsp_load;
      logic rsp_refused;
      logic rsp_use_rdata;
   } fbfill_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             pix_ok;
      logic             rect_ok;
      logic             rect_empty;
      logic             col_last;
      logic             row_last;
      logic             clr_last;
      logic             rsp_busy;
   } fbfill_stat_type;

endpackage

/* rtl/fbfill_ram.sv */
// Generic single-port RAM with registered read data.
// Used for the frame store; depends on no package.
module fbfill_ram #(
   parameter  int DATA_W = 16,
   parameter  int DEPTH  = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic              re,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   // One access a cycle; read data is registered and held between reads.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/fbfill_ctrl.sv */
// Controller state machine of the framebuffer engine.
// Sequences each request through bounds check, memory access and response; uses fbfill_pkg.
module fbfill_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  fbfill_pkg::fbfill_stat_type stat,
   output fbfill_pkg::fbfill_cmd_type  cmd
);
   import fbfill_pkg::*;

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_CALC    = 4'd1;
   localparam logic [3:0] ST_WRITE   = 4'd2;
   localparam logic [3:0] ST_READ    = 4'd3;
   localparam logic [3:0] ST_FILL    = 4'd4;
   localparam logic [3:0] ST_CLEAR   = 4'd5;
   localparam logic [3:0] ST_DONE    = 4'd6;
   localparam logic [3:0] ST_DONE_RD = 4'd7;
   localparam logic [3:0] ST_REFUSE  = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_tready = (state_ff == ST_IDLE);

   // Next state and commands to the datapath.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load_req = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            unique case (stat.cmd)
               CMD_WRITE: state_in = stat.pix_ok ? ST_WRITE : ST_REFUSE;
               CMD_READ:  state_in = stat.pix_ok ? ST_READ : ST_REFUSE;
               CMD_FILL: begin
                  if (!stat.rect_ok) begin
                     state_in = ST_REFUSE;
                  end else if (stat.rect_empty) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_FILL;
                  end
               end
               CMD_CLEAR: state_in = ST_CLEAR;
               default:   state_in = ST_REFUSE;
            endcase
         end
         ST_WRITE: begin
            cmd.pix_write = 1'b1;
            state_in      = ST_DONE;
         end
         ST_READ: begin
            cmd.pix_read = 1'b1;
            state_in     = ST_DONE_RD;
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (stat.col_last && stat.row_last) begin
               state_in = ST_DONE;
            end
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clr_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_DONE_RD: begin
            if (!stat.rsp_busy) begin
               cmd.rsp_load      = 1'b1;
               cmd.rsp_use_rdata = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         ST_REFUSE: begin
            if (!stat.rsp_busy) begin
               cmd.rsp_load    = 1'b1;
               cmd.rsp_refused = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/fbfill_dp.sv */
// Datapath of the framebuffer engine: request registers, bounds checks,
// address counters, frame store and response register. Uses fbfill_pkg and fbfill_ram.
module fbfill_dp #(
   parameter int SCREEN_WIDTH  = fbfill_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = fbfill_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [fbfill_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [fbfill_pkg::CMD_W-1:0]        req_tuser,
   input  fbfill_pkg::fbfill_cmd_type          cmd,
   output fbfill_pkg::fbfill_stat_type         stat,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [fbfill_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                                rsp_tuser
);
   import fbfill_pkg::*;

   localparam int DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [ADDR_W-1:0]  WIDTH_A  = ADDR_W'(SCREEN_WIDTH);
   localparam logic [ADDR_W-1:0]  LAST_A   = ADDR_W'(DEPTH - 1);
   localparam logic [COORD_W-1:0] WIDTH_C  = COORD_W'(SCREEN_WIDTH);
   localparam logic [COORD_W-1:0] HEIGHT_C = COORD_W'(SCREEN_HEIGHT);

   // Request registers.
   logic [CMD_W-1:0]   cmd_ff;
   logic [COORD_W-1:0] x_ff;
   logic [COORD_W-1:0] y_ff;
   logic [SIZE_W-1:0]  w_ff;
   logic [SIZE_W-1:0]  h_ff;
   logic [COLOR_W-1:0] color_ff;

   // Address counters.
   logic [ADDR_W-1:0]  row_base_ff;
   logic [ADDR_W-1:0]  row_base_in;
   logic [SIZE_W-1:0]  col_ff;
   logic [SIZE_W-1:0]  rows_left_ff;
   logic [ADDR_W-1:0]  clr_addr_ff;

   // Response register.
   logic               rsp_valid_ff;
   logic [COLOR_W-1:0] rsp_color_ff;
   logic               rsp_status_ff;

   logic [COORD_W-1:0] x_abs;
   logic [COORD_W-1:0] y_abs;
   logic [COORD_W-1:0] x_end;
   logic [COORD_W-1:0] y_end;
   logic [COORD_W-1:0] col_next;
   logic [ADDR_W-1:0]  pix_addr;
   logic [ADDR_W-1:0]  fill_addr;
   logic               ram_we;
   logic               ram_re;
   logic [ADDR_W-1:0]  ram_addr;
   logic [COLOR_W-1:0] ram_rdata;

   // Capture the request when it is taken.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cmd_ff   <= req_tuser;
         x_ff     <= req_tdata[POS_X_LSB +: COORD_W];
         y_ff     <= req_tdata[POS_Y_LSB +: COORD_W];
         w_ff     <= req_tdata[RECT_W_LSB +: SIZE_W];
         h_ff     <= req_tdata[RECT_H_LSB +: SIZE_W];
         color_ff <= req_tdata[COLOR_LSB +: COLOR_W];
      end
   end

   // Bounds checks on the stored request.
   always_comb begin
      x_abs    = {1'b0, x_ff[SIZE_W-1:0]};
      y_abs    = {1'b0, y_ff[SIZE_W-1:0]};
      x_end    = x_abs + {1'b0, w_ff};
      y_end    = y_abs + {1'b0, h_ff};
      col_next = {1'b0, col_ff} + COORD_W'(1);

      stat.cmd        = cmd_ff;
      stat.pix_ok     = !x_ff[COORD_W-1] && !y_ff[COORD_W-1] &&
                        (x_abs < WIDTH_C) && (y_abs < HEIGHT_C);
      stat.rect_ok    = !x_ff[COORD_W-1] && !y_ff[COORD_W-1] &&
                        (x_end <= WIDTH_C) && (y_end <= HEIGHT_C);
      stat.rect_empty = (w_ff == '0) || (h_ff == '0);
      stat.col_last   = (col_next == x_end);
      stat.row_last   = (rows_left_ff == SIZE_W'(1));
      stat.clr_last   = (clr_addr_ff == LAST_A);
      stat.rsp_busy   = rsp_valid_ff && !rsp_tready;
   end

   // Row base: one multiply when the request is checked, then one add per row.
   always_comb begin
      row_base_in = row_base_ff;
      if (cmd.calc) begin
         row_base_in = ADDR_W'(ADDR_W'(y_ff[SIZE_W-1:0]) * WIDTH_A);
      end else if (cmd.fill_step && stat.col_last) begin
         row_base_in = row_base_ff + WIDTH_A;
      end
   end

   // Column, row and clear counters.
   always_ff @(posedge clock) begin
      row_base_ff <= row_base_in;
      if (cmd.calc) begin
         col_ff       <= x_ff[SIZE_W-1:0];
         rows_left_ff <= h_ff;
         clr_addr_ff  <= '0;
      end else begin
         if (cmd.fill_step) begin
            if (stat.col_last) begin
               col_ff       <= x_ff[SIZE_W-1:0];
               rows_left_ff <= rows_left_ff - SIZE_W'(1);
            end else begin
               col_ff <= col_next[SIZE_W-1:0];
            end
         end
         if (cmd.clear_step) begin
            clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         end
      end
   end

   // Frame store port selection.
   assign pix_addr  = row_base_ff + ADDR_W'(x_ff[SIZE_W-1:0]);
   assign fill_addr = row_base_ff + ADDR_W'(col_ff);
   assign ram_we    = cmd.pix_write || cmd.fill_step || cmd.clear_step;
   assign ram_re    = cmd.pix_read;

   always_comb begin
      priority if (cmd.pix_write || cmd.pix_read) begin
         ram_addr = pix_addr;
      end else if (cmd.fill_step) begin
         ram_addr = fill_addr;
      end else begin
         ram_addr = clr_addr_ff;
      end
   end

   fbfill_ram #(
      .DATA_W (COLOR_W),
      .DEPTH  (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (color_ff),
      .rdata (ram_rdata)
   );

   // Response register; a new response is loaded only once the slot is free.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_color_ff  <= cmd.rsp_use_rdata ? ram_rdata : '0;
         rsp_status_ff <= cmd.rsp_refused;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_color_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

/* rtl/framebuffer_pixel_and_fill_engine_unit.sv */
// Framebuffer pixel and fill engine: one request in, one response out per command.
// A pixel write or read runs through the bounds check, the memory access and the response load;
// a refusal or an empty fill goes from the check to the response, a fill writes its pixels one
// by one and a clear steps through all WIDTH*HEIGHT addresses. The next request is taken in the
// cycle after the response is loaded; a pending response in the output register holds up only the
// end of the next request. Reset clears the control state only; the frame store stays undefined.
module framebuffer_pixel_and_fill_engine_unit #(
   parameter int SCREEN_WIDTH  = fbfill_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = fbfill_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // pos_x[11:0], pos_y[23:12], rect_width[34:24], rect_height[45:35],
   // pixel_color[61:46], zero[63:62]
   input  logic [fbfill_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd[1:0]
   input  logic [fbfill_pkg::CMD_W-1:0]      req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // read_color[15:0]
   output logic [fbfill_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status[0]
   output logic                              rsp_tuser
);
   import fbfill_pkg::*;

   fbfill_cmd_type  ctrl_cmd;
   fbfill_stat_type dp_stat;

   fbfill_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (dp_stat),
      .cmd        (ctrl_cmd)
   );

   fbfill_dp #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (ctrl_cmd),
      .stat       (dp_stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // The engine works on one request at a time.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while the previous one was still being processed");

   // A refused command never returns pixel data.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("refused response carries a nonzero colour");

   // At most one frame store operation is commanded in a cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl_cmd.pix_write, ctrl_cmd.pix_read, ctrl_cmd.fill_step,
                ctrl_cmd.clear_step}))
      else $error("conflicting frame store commands");

   // A response is loaded only when the output slot is free, so none is overwritten.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !ctrl_cmd.rsp_load)
      else $error("response overwritten before it was taken");

endmodule
